/* rtl/rbd_pkg.sv */
// Package with the shared constants and types of the RGB diamond blur.
`default_nettype none
package rbd_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_SIZE     = 5;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int FW_W         = 11;
    localparam int FH_W         = 13;
    localparam int KW_W         = 8;
    localparam int PIX_W        = 24;
    localparam int CH_W         = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int LINES        = 4;
    localparam int WIN          = 5;
    localparam int SUM_W        = 19;
    localparam int TOTAL_W      = 11;
    localparam int QUOT_W       = 8;
    localparam int STEP_W       = $clog2(QUOT_W);

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [CH_W-1:0]  chan_t;

endpackage
`default_nettype wire

/* rtl/rbd_if.sv */
// Stream interfaces for incoming pixels and filtered result pixels.
`default_nettype none
interface rbd_pixel_if;
    logic                    valid;
    logic                    ready;
    logic [rbd_pkg::CH_W-1:0] in_red;
    logic [rbd_pkg::CH_W-1:0] in_green;
    logic [rbd_pkg::CH_W-1:0] in_blue;
    logic                    start_of_frame;

    modport source (output valid, in_red, in_green, in_blue, start_of_frame, input ready);
    modport sink (input valid, in_red, in_green, in_blue, start_of_frame, output ready);
endinterface

interface rbd_result_if;
    logic                    valid;
    logic                    ready;
    logic [rbd_pkg::CH_W-1:0] out_red;
    logic [rbd_pkg::CH_W-1:0] out_green;
    logic [rbd_pkg::CH_W-1:0] out_blue;
    logic                    last_of_frame;

    modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
    modport sink (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface
`default_nettype wire

/* rtl/rgb_blur_5x5_diamond_core.sv */
// Top level of the streaming 5x5 diamond blur of RGB pixels.
//
//  port           dir   handshake      payload
//  pixel_stream   sink  valid/ready    in_red, in_green, in_blue, start_of_frame
//  blur_stream    src   valid/ready    out_red, out_green, out_blue, last_of_frame
//  cfg_*          in    cfg_write      cfg_index, cfg_data
//
// A pixel with no result passes IDLE and READ, with k = 0 also DONE, with k > 0
// also SUM, MUL, ADD, the shared bit-per-cycle divider DIV and DONE. The line store
// is one 1024 x 96 memory, read at acceptance and written back in the next cycle, so
// accesses never overlap. Reset clears the window, counters and flags; the line
// store and data registers are not cleared. A stalled result waits in the output
// register while the next pixel is taken; a second result waits for it to drain.
`default_nettype none
module rgb_blur_5x5_diamond_core (
    input  wire                              clk,
    input  wire                              rst_n,
    rbd_pixel_if.sink                        pixel_stream,
    rbd_result_if.source                     blur_stream,
    input  wire                              cfg_write,
    input  wire [rbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [rbd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rbd_pkg::*;

    localparam int MEM_W = LINES * PIX_W;

    state_t                 state_reg, state_next;

    logic [KW_W-1:0]        kernel_weight_reg;
    logic [FW_W-1:0]        frame_width_reg;
    logic [FH_W-1:0]        frame_height_reg;

    logic [COL_W-1:0]       column_count_reg;
    logic [ROW_W-1:0]       row_count_reg;
    logic [COL_W-1:0]       col_reg;
    logic                   emit_reg;
    logic                   last_reg;
    pixel_t                 pix_reg;

    logic [MEM_W-1:0]       line_mem [MAX_WIDTH];
    logic [MEM_W-1:0]       rd_data_reg;

    pixel_t                 win_reg [WIN][WIN];

    logic [2:0][CH_W-1:0]   center_reg;
    logic [2:0][9:0]        ring1_reg;
    logic [2:0][10:0]       ring2_reg;
    logic [2:0][15:0]       prod_c_reg;
    logic [2:0][16:0]       prod_1_reg;
    logic [2:0][16:0]       prod_2_reg;
    logic [2:0][SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]       dsr_reg;
    logic [2:0][QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0]      step_reg;

    logic                   out_valid_reg;
    logic [2:0][CH_W-1:0]   out_chan_reg;
    logic                   out_last_reg;

    logic                   accept;
    logic                   in_ready;
    logic                   load_out;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    logic [FW_W-1:0]        w_eff;
    logic [FH_W-1:0]        h_eff;
    logic                   col_wrap;
    logic                   row_wrap;
    logic [TOTAL_W-1:0]     total;
    logic [6:0]             k_half;
    logic [5:0]             k_quarter;

    assign k_half    = kernel_weight_reg[KW_W-1:1];
    assign k_quarter = kernel_weight_reg[KW_W-1:2];
    assign total     = TOTAL_W'(kernel_weight_reg) + {2'b00, k_half, 2'b00}
                     + {2'b00, k_quarter, 3'b000};

    always_comb
    begin
        if (frame_width_reg < FW_W'(MIN_SIZE))
            w_eff = FW_W'(MIN_SIZE);
        else if (frame_width_reg > FW_W'(MAX_WIDTH))
            w_eff = FW_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg < FH_W'(MIN_SIZE))
            h_eff = FH_W'(MIN_SIZE);
        else if (frame_height_reg > FH_W'(HEIGHT_LIMIT))
            h_eff = FH_W'(HEIGHT_LIMIT);
        else
            h_eff = frame_height_reg;
    end

    assign col      = pixel_stream.start_of_frame ? '0 : column_count_reg;
    assign row      = pixel_stream.start_of_frame ? '0 : row_count_reg;
    assign col_wrap = (FW_W'(col) + FW_W'(1)) >= w_eff;
    assign row_wrap = (FH_W'(row) + FH_W'(1)) >= h_eff;
    assign accept   = pixel_stream.valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_stream.valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (!emit_reg)
                    state_next = ST_IDLE;
                else if (kernel_weight_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_SUM;
            end
            ST_SUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == STEP_W'(QUOT_W - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || blur_stream.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DONE: load_out = !out_valid_reg || blur_stream.ready;
            default:
            begin
                in_ready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            kernel_weight_reg <= KW_W'(4);
            frame_width_reg   <= FW_W'(640);
            frame_height_reg  <= FH_W'(480);
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            emit_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
            for (int r = 0; r < WIN; r++)
                for (int c = 0; c < WIN; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KERNEL_WEIGHT: kernel_weight_reg <= cfg_data[KW_W-1:0];
                    REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[FH_W-1:0];
                    default:           kernel_weight_reg <= kernel_weight_reg;
                endcase
            end
            if (accept)
            begin
                emit_reg <= (col >= COL_W'(4)) && (row >= ROW_W'(4));
                if (col_wrap)
                begin
                    column_count_reg <= '0;
                    row_count_reg    <= row_wrap ? '0 : row + ROW_W'(1);
                end
                else
                begin
                    column_count_reg <= col + COL_W'(1);
                    row_count_reg    <= row;
                end
            end
            if (state_reg == ST_READ)
            begin
                for (int r = 0; r < WIN; r++)
                    for (int c = 0; c < WIN - 1; c++)
                        win_reg[r][c] <= win_reg[r][c+1];
                win_reg[0][WIN-1] <= rd_data_reg[4*PIX_W-1:3*PIX_W];
                win_reg[1][WIN-1] <= rd_data_reg[3*PIX_W-1:2*PIX_W];
                win_reg[2][WIN-1] <= rd_data_reg[2*PIX_W-1:PIX_W];
                win_reg[3][WIN-1] <= rd_data_reg[PIX_W-1:0];
                win_reg[4][WIN-1] <= pix_reg;
            end
            if (state_reg == ST_ADD)
                step_reg <= '0;
            else if (state_reg == ST_DIV)
                step_reg <= step_reg + STEP_W'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (blur_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[col];
            col_reg     <= col;
            last_reg    <= (FW_W'(col) == w_eff - FW_W'(1))
                        && (FH_W'(row) == h_eff - FH_W'(1));
            pix_reg     <= {pixel_stream.in_red, pixel_stream.in_green,
                            pixel_stream.in_blue};
        end
        if (state_reg == ST_READ)
            line_mem[col_reg] <= {rd_data_reg[3*PIX_W-1:0], pix_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (state_reg == ST_SUM)
            begin
                center_reg[ch] <= win_reg[2][2][CH_W*(2-ch) +: CH_W];
                ring1_reg[ch]  <= 10'(win_reg[1][2][CH_W*(2-ch) +: CH_W])
                                + 10'(win_reg[3][2][CH_W*(2-ch) +: CH_W])
                                + 10'(win_reg[2][1][CH_W*(2-ch) +: CH_W])
                                + 10'(win_reg[2][3][CH_W*(2-ch) +: CH_W]);
                ring2_reg[ch]  <= 11'(win_reg[0][2][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[4][2][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[2][0][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[2][4][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[1][1][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[1][3][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[3][1][CH_W*(2-ch) +: CH_W])
                                + 11'(win_reg[3][3][CH_W*(2-ch) +: CH_W]);
            end
            if (state_reg == ST_MUL)
            begin
                prod_c_reg[ch] <= 16'(center_reg[ch]) * 16'(kernel_weight_reg);
                prod_1_reg[ch] <= 17'(ring1_reg[ch]) * 17'(k_half);
                prod_2_reg[ch] <= 17'(ring2_reg[ch]) * 17'(k_quarter);
            end
            if (state_reg == ST_ADD)
            begin
                rem_reg[ch]  <= SUM_W'(prod_c_reg[ch]) + SUM_W'(prod_1_reg[ch])
                              + SUM_W'(prod_2_reg[ch]);
                quot_reg[ch] <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                if (rem_reg[ch] >= dsr_reg)
                begin
                    rem_reg[ch]  <= rem_reg[ch] - dsr_reg;
                    quot_reg[ch] <= {quot_reg[ch][QUOT_W-2:0], 1'b1};
                end
                else
                    quot_reg[ch] <= {quot_reg[ch][QUOT_W-2:0], 1'b0};
            end
            if (load_out)
                out_chan_reg[ch] <= (kernel_weight_reg == '0)
                                  ? win_reg[2][2][CH_W*(2-ch) +: CH_W]
                                  : quot_reg[ch];
        end
        if (state_reg == ST_ADD)
            dsr_reg <= {1'b0, total, 7'b0000000};
        else if (state_reg == ST_DIV)
            dsr_reg <= {1'b0, dsr_reg[SUM_W-1:1]};
        if (load_out)
            out_last_reg <= last_reg;
    end

    assign pixel_stream.ready      = in_ready;
    assign blur_stream.valid       = out_valid_reg;
    assign blur_stream.out_red     = out_chan_reg[0];
    assign blur_stream.out_green   = out_chan_reg[1];
    assign blur_stream.out_blue    = out_chan_reg[2];
    assign blur_stream.last_of_frame = out_last_reg;

endmodule
`default_nettype wire
